// ===== design/bapsd_pkg.sv =====
// Shared types, constants and helpers of the bus access profiler with spin detection.
// Depends on nothing; bapsd_front, bapsd_back, the top level and the testbench import it.
package bapsd_pkg;

  localparam int SITE_SLOTS_DEF = 64;
  localparam int QUEUE_DEPTH    = 2;
  localparam int BAR_W          = 3;
  localparam int OFFSET_W       = 32;
  localparam int AWIDTH_W       = 4;
  localparam int CNT_W          = 32;
  localparam int SLOT_OUT_W     = 6;
  localparam int IN_DATA_W      = 48;
  localparam int OUT_DATA_W     = 144;
  localparam logic [CNT_W-1:0] THRESH_RESET = 32'd1000;

  typedef struct packed {
    logic                is_modeled;
    logic                is_write;
    logic [AWIDTH_W-1:0] access_width;
    logic [OFFSET_W-1:0] offset;
    logic [BAR_W-1:0]    bar;
  } access_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    access_t acc;
    logic    recorded;
    logic    dropped;
    logic    fresh;
  } entry_t;

  typedef struct packed {
    logic [AWIDTH_W-1:0] width;
    logic [CNT_W-1:0]    reads;
    logic [CNT_W-1:0]    writes;
  } site_t;

  typedef struct packed {
    logic                  site_dropped;
    logic                  site_recorded;
    logic [CNT_W-1:0]      site_writes;
    logic [CNT_W-1:0]      site_reads;
    logic [SLOT_OUT_W-1:0] site_slot;
    logic [CNT_W-1:0]      warning_total;
    logic [CNT_W-1:0]      run_length;
    logic                  spin_warn;
  } result_t;

  localparam int IN_PAD_W  = IN_DATA_W - $bits(access_t);
  localparam int OUT_PAD_W = OUT_DATA_W - $bits(result_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== design/bapsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bapsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bapsd_queue.sv =====
// Short FIFO that decouples the classifying front from the executing back.
// Depends on nothing.
module bapsd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/bapsd_front.sv =====
// Front end: parallel key compare over the site table and slot allocation.
// Depends on bapsd_pkg.
module bapsd_front
  import bapsd_pkg::*;
#(
  parameter int SITE_SLOTS = SITE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  access_t                       acc,
  input  logic                          accept,
  output entry_t                        entry,
  output logic [$clog2(SITE_SLOTS)-1:0] slot
);

  localparam int SLOT_W = $clog2(SITE_SLOTS);
  localparam int USED_W = $clog2(SITE_SLOTS + 1);

  logic                key_valid_r [SITE_SLOTS];
  logic [BAR_W-1:0]    key_bar_r   [SITE_SLOTS];
  logic [OFFSET_W-1:0] key_off_r   [SITE_SLOTS];
  logic [USED_W-1:0]   used_r, used_nxt;

  logic [SITE_SLOTS-1:0] hit;
  logic                  hit_any;
  logic [SLOT_W-1:0]     hit_idx;
  logic                  room;
  logic                  alloc;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SITE_SLOTS; i++) begin
      hit[i] = key_valid_r[i] && (key_bar_r[i] == acc.bar) && (key_off_r[i] == acc.offset);
      if (hit[i]) begin
        hit_idx = hit_idx | SLOT_W'(i);
      end
    end
  end

  assign hit_any = |hit;
  assign room    = (used_r < USED_W'(SITE_SLOTS));
  assign alloc   = !acc.is_modeled && !hit_any && room;

  always_comb begin
    entry.acc      = acc;
    entry.recorded = !acc.is_modeled && (hit_any || room);
    entry.dropped  = !acc.is_modeled && !hit_any && !room;
    entry.fresh    = alloc;
    if (hit_any && !acc.is_modeled) begin
      slot = hit_idx;
    end else if (alloc) begin
      slot = used_r[SLOT_W-1:0];
    end else begin
      slot = '0;
    end
    used_nxt = (accept && alloc) ? used_r + 1'b1 : used_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < SITE_SLOTS; i++) begin
        key_valid_r[i] <= 1'b0;
      end
    end else begin
      used_r <= used_nxt;
      if (accept && alloc) begin
        key_valid_r[used_r[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && alloc) begin
      key_bar_r[used_r[SLOT_W-1:0]] <= acc.bar;
      key_off_r[used_r[SLOT_W-1:0]] <= acc.offset;
    end
  end

endmodule

// ===== design/bapsd_back.sv =====
// Back end: site counter read-modify-write, spin run tracking and result register.
// Depends on bapsd_pkg and bapsd_ram.
module bapsd_back
  import bapsd_pkg::*;
#(
  parameter int SITE_SLOTS = SITE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  entry_t                        q_entry,
  input  logic [$clog2(SITE_SLOTS)-1:0] q_slot,
  output logic                          q_pop,
  input  logic [CNT_W-1:0]              threshold,
  output logic                          out_valid,
  output result_t                       out_result,
  input  logic                          out_ready
);

  localparam int SLOT_W = $clog2(SITE_SLOTS);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_CALC = 2'b10
  } bk_state_t;

  bk_state_t         state_r, state_nxt;
  entry_t            cur_r;
  logic [SLOT_W-1:0] cur_slot_r;

  logic [BAR_W-1:0]    run_bar_r, run_bar_nxt;
  logic [OFFSET_W-1:0] run_off_r, run_off_nxt;
  logic [CNT_W-1:0]    run_cnt_r, run_cnt_nxt;
  logic                run_warned_r, run_warned_nxt;
  logic [CNT_W-1:0]    warn_total_r, warn_total_nxt;
  logic                out_valid_r, out_valid_nxt;
  result_t             out_result_r;

  site_t   site_rd;
  site_t   site_wr;
  logic    out_free;
  logic    finish;
  logic    warn;
  result_t res;

  bapsd_ram #(
    .WIDTH ($bits(site_t)),
    .DEPTH (SITE_SLOTS)
  ) u_site_ram (
    .clk   (clk),
    .we    (finish && cur_r.recorded),
    .waddr (cur_slot_r),
    .wdata (site_wr),
    .re    (q_pop),
    .raddr (q_slot),
    .rdata (site_rd)
  );

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == BK_IDLE) && q_valid;
  assign finish   = (state_r == BK_CALC) && out_free;

  always_comb begin
    site_wr.width  = cur_r.acc.access_width;
    site_wr.reads  = cur_r.fresh ? '0 : site_rd.reads;
    site_wr.writes = cur_r.fresh ? '0 : site_rd.writes;
    if (cur_r.acc.is_write) begin
      site_wr.writes = sat_inc(site_wr.writes);
    end else begin
      site_wr.reads = sat_inc(site_wr.reads);
    end
  end

  always_comb begin
    run_bar_nxt    = run_bar_r;
    run_off_nxt    = run_off_r;
    run_cnt_nxt    = run_cnt_r;
    run_warned_nxt = run_warned_r;
    warn_total_nxt = warn_total_r;
    warn           = 1'b0;
    if (cur_r.acc.is_write) begin
      run_cnt_nxt    = '0;
      run_warned_nxt = 1'b0;
    end else begin
      if ((run_cnt_r != '0) && (run_bar_r == cur_r.acc.bar)
          && (run_off_r == cur_r.acc.offset)) begin
        run_cnt_nxt = sat_inc(run_cnt_r);
      end else begin
        run_bar_nxt    = cur_r.acc.bar;
        run_off_nxt    = cur_r.acc.offset;
        run_cnt_nxt    = {{(CNT_W-1){1'b0}}, 1'b1};
        run_warned_nxt = 1'b0;
      end
      if ((run_cnt_nxt >= threshold) && !run_warned_nxt) begin
        run_warned_nxt = 1'b1;
        warn_total_nxt = sat_inc(warn_total_r);
        warn           = 1'b1;
      end
    end
  end

  always_comb begin
    res.spin_warn     = warn;
    res.run_length    = run_cnt_nxt;
    res.warning_total = warn_total_nxt;
    res.site_slot     = cur_r.recorded ? SLOT_OUT_W'(cur_slot_r) : '0;
    res.site_reads    = cur_r.recorded ? site_wr.reads : '0;
    res.site_writes   = cur_r.recorded ? site_wr.writes : '0;
    res.site_recorded = cur_r.recorded;
    res.site_dropped  = cur_r.dropped;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          state_nxt = BK_CALC;
        end
      end
      BK_CALC: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_valid_r  <= 1'b0;
      run_bar_r    <= '0;
      run_off_r    <= '0;
      run_cnt_r    <= '0;
      run_warned_r <= 1'b0;
      warn_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (finish) begin
        run_bar_r    <= run_bar_nxt;
        run_off_r    <= run_off_nxt;
        run_cnt_r    <= run_cnt_nxt;
        run_warned_r <= run_warned_nxt;
        warn_total_r <= warn_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r      <= q_entry;
      cur_slot_r <= q_slot;
    end
    if (finish) begin
      out_result_r <= res;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ===== design/bus_access_profiler_spin_detect.sv =====
// Top level of the bus access profiler with spin detection.
// Depends on bapsd_pkg, bapsd_front, bapsd_queue and bapsd_back.
//
// Usage: each request on the in_ stream is one register access; for every
// request exactly one result leaves on the out_ stream, in request order.
// The front compares the access key against all site table keys combinationally
// and claims a free slot for a new key; the classified request then
// waits in a two-entry queue. The back reads the slot counters from a RAM,
// updates them and the polling run state, and loads the output register.
// The back takes one request at a time: it pops the next only after the counter
// RAM read-modify-write of the current one is done. An accepted request passes
// through the queue, the back's idle and calc states and the output register.
// in_tready drops only when the queue is full; a stalled receiver holds the
// result in the output register and the back waits, so nothing is lost.
// cfg_ready is always high; the spin threshold is written through cfg_data.
// Reset clears the site table valid bits, the slot count, the run state,
// the warning total and sets the spin threshold to 1000; no clearing pass.
module bus_access_profiler_spin_detect
  import bapsd_pkg::*;
#(
  parameter int SITE_SLOTS = SITE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: bar, offset, access_width, is_write, is_modeled, zero pad.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: spin_warn, run_length, warning_total, site_slot,
  // site_reads, site_writes, site_recorded, site_dropped, zero pad.
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int SLOT_W  = $clog2(SITE_SLOTS);
  localparam int ENTRY_W = $bits(entry_t) + SLOT_W;

  logic [CNT_W-1:0]  thresh_r;
  access_t           acc;
  logic              accept;
  entry_t            f_entry;
  logic [SLOT_W-1:0] f_slot;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [ENTRY_W-1:0] q_data;
  entry_t            q_entry;
  logic [SLOT_W-1:0] q_slot;
  result_t           res;

  assign acc       = access_t'(in_tdata[$bits(access_t)-1:0]);
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh_r <= cfg_data;
    end
  end

  bapsd_front #(
    .SITE_SLOTS (SITE_SLOTS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .accept (accept),
    .entry  (f_entry),
    .slot   (f_slot)
  );

  bapsd_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data ({f_entry, f_slot}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  assign q_entry = entry_t'(q_data[ENTRY_W-1:SLOT_W]);
  assign q_slot  = q_data[SLOT_W-1:0];

  bapsd_back #(
    .SITE_SLOTS (SITE_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_slot     (q_slot),
    .q_pop      (q_pop),
    .threshold  (thresh_r),
    .out_valid  (out_tvalid),
    .out_result (res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res};

endmodule

// ===== tb/tb_bus_access_profiler_spin_detect.sv =====
// Self-checking testbench for the bus access profiler with spin detection.
// Imports bapsd_pkg and drives bus_access_profiler_spin_detect; predicts every result
// from its own site table and polling-run model and compares results field by field.
module tb_bus_access_profiler_spin_detect;
  import bapsd_pkg::*;

  localparam int SLOTS          = SITE_SLOTS_DEF;
  localparam int POOL_KEYS      = 40;
  localparam int PHASE_ITEMS    = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF       = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      cfg_data = '0;

  // Predicted state of the site table and the polling run.
  bit                  site_live [SLOTS];
  logic [BAR_W-1:0]    site_bar [SLOTS];
  logic [OFFSET_W-1:0] site_ofs [SLOTS];
  logic [CNT_W-1:0]    site_rd [SLOTS];
  logic [CNT_W-1:0]    site_wr [SLOTS];
  int                  sites_taken = 0;
  logic [BAR_W-1:0]    poll_bar = '0;
  logic [OFFSET_W-1:0] poll_ofs = '0;
  logic [CNT_W-1:0]    poll_len = '0;
  bit                  poll_flagged = 1'b0;
  logic [CNT_W-1:0]    warn_count = '0;
  logic [CNT_W-1:0]    spin_limit = THRESH_RESET;

  result_t             expected_results [$];
  result_t             seen_result;
  result_t             want_result;

  logic [BAR_W-1:0]    pool_bar [POOL_KEYS];
  logic [OFFSET_W-1:0] pool_ofs [POOL_KEYS];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_cycles = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int accesses_sent = 0;
  int warns_predicted = 0;
  int drops_predicted = 0;
  int limit_writes = 0;

  bus_access_profiler_spin_detect dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic result_t predict_access(input access_t acc);
    result_t r;
    int      hit;
    int      i;
    r   = '0;
    hit = -1;
    if (!acc.is_modeled) begin
      for (i = 0; i < SLOTS; i++) begin
        if (hit < 0 && site_live[i] && site_bar[i] == acc.bar && site_ofs[i] == acc.offset)
          hit = i;
      end
      if (hit < 0 && sites_taken < SLOTS) begin
        hit = sites_taken;
        sites_taken++;
        site_live[hit] = 1'b1;
        site_bar[hit]  = acc.bar;
        site_ofs[hit]  = acc.offset;
        site_rd[hit]   = '0;
        site_wr[hit]   = '0;
      end
      if (hit >= 0) begin
        if (acc.is_write) site_wr[hit] = bump(site_wr[hit]);
        else site_rd[hit] = bump(site_rd[hit]);
        r.site_slot     = SLOT_OUT_W'(hit);
        r.site_reads    = site_rd[hit];
        r.site_writes   = site_wr[hit];
        r.site_recorded = 1'b1;
      end else begin
        r.site_dropped = 1'b1;
        drops_predicted++;
      end
    end
    if (acc.is_write) begin
      poll_len     = '0;
      poll_flagged = 1'b0;
    end else begin
      if (poll_len != 0 && poll_bar == acc.bar && poll_ofs == acc.offset) begin
        poll_len = bump(poll_len);
      end else begin
        poll_bar     = acc.bar;
        poll_ofs     = acc.offset;
        poll_len     = 1;
        poll_flagged = 1'b0;
      end
      if (poll_len >= spin_limit && !poll_flagged) begin
        poll_flagged = 1'b1;
        warn_count   = bump(warn_count);
        r.spin_warn  = 1'b1;
        warns_predicted++;
      end
    end
    r.run_length    = poll_len;
    r.warning_total = warn_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = out_tdata[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, seen_result);
      end else begin
        want_result = expected_results.pop_front();
        check_field("spin_warn", CNT_W'(want_result.spin_warn),
                    CNT_W'(seen_result.spin_warn));
        check_field("run_length", want_result.run_length, seen_result.run_length);
        check_field("warning_total", want_result.warning_total, seen_result.warning_total);
        check_field("site_slot", CNT_W'(want_result.site_slot),
                    CNT_W'(seen_result.site_slot));
        check_field("site_reads", want_result.site_reads, seen_result.site_reads);
        check_field("site_writes", want_result.site_writes, seen_result.site_writes);
        check_field("site_recorded", CNT_W'(want_result.site_recorded),
                    CNT_W'(seen_result.site_recorded));
        check_field("site_dropped", CNT_W'(want_result.site_dropped),
                    CNT_W'(seen_result.site_dropped));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver holds off each result for a random number of cycles while rx_idle is
  // set, or for a long stretch when a hold-off is requested.
  initial begin : result_sink
    int wait_cycles;
    forever begin
      if (hold_cycles != 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (wait_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_access(input logic [BAR_W-1:0] bar, input logic [OFFSET_W-1:0] ofs,
                             input logic [AWIDTH_W-1:0] width, input bit wr,
                             input bit modeled);
    access_t acc;
    int      gap;
    result_t want;
    acc.bar          = bar;
    acc.offset       = ofs;
    acc.access_width = width;
    acc.is_write     = wr;
    acc.is_modeled   = modeled;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, acc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_access(acc);
    expected_results.insert(expected_results.size(), want);
    accesses_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_poll_limit(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    spin_limit = value;
    limit_writes++;
  endtask

  task automatic test_default_threshold();
    send_access(3'd0, 32'h0000_0000, 4'd0, 1'b0, 1'b1);
    send_access(3'd7, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1);
    send_access(3'd7, 32'hFFFF_FFFF, 4'd8, 1'b0, 1'b0);
    send_access(3'd7, 32'hFFFF_FFFF, 4'd4, 1'b0, 1'b0);
    send_access(3'd7, 32'hFFFF_FFFF, 4'd2, 1'b1, 1'b0);
    send_access(3'd7, 32'hFFFF_FFFF, 4'd1, 1'b0, 1'b0);
    send_access(3'd0, 32'hFFFF_FFFF, 4'd8, 1'b0, 1'b0);
    send_access(3'd7, 32'h0000_0000, 4'd1, 1'b0, 1'b0);
    send_access(3'd5, 32'hA5A5_5A5A, 4'd4, 1'b1, 1'b0);
    drain_results();
  endtask

  task automatic test_threshold_edges();
    set_poll_limit(32'd1);
    send_access(3'd1, 32'h0000_1000, 4'd4, 1'b0, 1'b0);
    send_access(3'd1, 32'h0000_1000, 4'd4, 1'b0, 1'b0);
    send_access(3'd2, 32'h0000_1000, 4'd4, 1'b0, 1'b0);
    send_access(3'd2, 32'h0000_1000, 4'd4, 1'b1, 1'b0);
    send_access(3'd2, 32'h0000_1000, 4'd4, 1'b0, 1'b0);
    // A zero threshold behaves like a threshold of one.
    set_poll_limit(32'd0);
    send_access(3'd3, 32'h8000_0000, 4'd2, 1'b0, 1'b0);
    send_access(3'd3, 32'h8000_0000, 4'd2, 1'b0, 1'b0);
    set_poll_limit(32'hFFFF_FFFF);
    repeat (3) send_access(3'd3, 32'h8000_0000, 4'd9, 1'b0, 1'b1);
    set_poll_limit(32'd3);
    repeat (4) send_access(3'd6, 32'h0000_0040, 4'd4, 1'b0, 1'b0);
    send_access(3'd6, 32'h0000_0044, 4'd4, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_backpressure();
    int n;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    hold_cycles = HOLD_OFF;
    for (n = 0; n < 24; n++)
      send_access(pool_bar[n % 6], pool_ofs[n % 6], $urandom_range(0, 15), n % 5 == 4,
                  n % 3 == 2);
    drain_results();
  endtask

  task automatic test_table_fill();
    int n;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (sites_taken < SLOTS)
      send_access($urandom_range(0, 7), $urandom, $urandom_range(0, 15),
                  $urandom_range(0, 1), 1'b0);
    for (n = 0; n < 8; n++)
      send_access($urandom_range(0, 7), $urandom, $urandom_range(0, 15), n % 2, 1'b0);
    for (n = 0; n < 4; n++)
      send_access(pool_bar[n], pool_ofs[n], $urandom_range(0, 15), 1'b0, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int first_phase, input int phases);
    int                  p;
    int                  sent;
    int                  len;
    int                  span;
    int                  k;
    int                  pick;
    logic [BAR_W-1:0]    key_bar;
    logic [OFFSET_W-1:0] key_ofs;
    logic [CNT_W-1:0]    limit;
    for (p = first_phase; p < first_phase + phases; p++) begin
      case (p % 8)
        0: limit = 32'd1;
        1: limit = $urandom_range(2, 5);
        2: limit = 32'd0;
        3: limit = $urandom_range(6, 12);
        4: limit = 32'hFFFF_FFFF;
        5: limit = $urandom_range(13, 24);
        6: limit = $urandom | 32'h8000_0000;
        default: limit = $urandom_range(2, 4);
      endcase
      set_poll_limit(limit);
      tx_idle = (p % 4 < 2);
      rx_idle = (p % 2 == 0);
      span = (limit >= 2 && limit <= 24) ? 2 * limit : 16;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 70) begin
          if ($urandom_range(0, 99) < 85) begin
            pick    = $urandom_range(0, POOL_KEYS - 1);
            key_bar = pool_bar[pick];
            key_ofs = pool_ofs[pick];
          end else begin
            key_bar = $urandom_range(0, 7);
            key_ofs = $urandom;
          end
          len = $urandom_range(1, span);
          for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
              send_access(key_bar, key_ofs, $urandom_range(0, 15), 1'b1,
                          $urandom_range(0, 3) == 0);
            end else if (pick < 10) begin
              pick = $urandom_range(0, POOL_KEYS - 1);
              send_access(pool_bar[pick], pool_ofs[pick], $urandom_range(0, 15), 1'b0,
                          $urandom_range(0, 1));
            end else begin
              send_access(key_bar, key_ofs, $urandom_range(0, 15), 1'b0,
                          $urandom_range(0, 3) == 0);
            end
            sent++;
          end
        end else begin
          pick = $urandom_range(0, POOL_KEYS - 1);
          send_access($urandom_range(0, 7), $urandom_range(0, 1) ? pool_ofs[pick] : $urandom,
                      $urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1));
          sent++;
        end
      end
    end
    drain_results();
  endtask

  initial begin : main
    int i;
    for (i = 0; i < POOL_KEYS; i++) begin
      if (i % 4 == 3) begin
        pool_ofs[i] = pool_ofs[i-1];
        pool_bar[i] = pool_bar[i-1] + 1'b1;
      end else begin
        pool_ofs[i] = $urandom;
        pool_bar[i] = $urandom_range(0, 7);
      end
    end
    pool_ofs[0] = 32'h0000_0000;
    pool_ofs[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_threshold();
    test_threshold_edges();
    test_backpressure();
    test_random_traffic(0, 4);
    test_table_fill();
    test_random_traffic(4, 4);

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d accesses over %0d threshold settings, including a long receiver stall.",
             accesses_sent, limit_writes);
    $display("Predicted %0d spin warnings and %0d accesses dropped by a full site table.",
             warns_predicted, drops_predicted);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bapsd_pkg.sv
design/bapsd_ram.sv
design/bapsd_queue.sv
design/bapsd_front.sv
design/bapsd_back.sv
design/bus_access_profiler_spin_detect.sv
tb/tb_bus_access_profiler_spin_detect.sv
